FILE: rtl/core/lzw_byte_compressor_assert.svh
// assertion macros shared by the lzw compressor modules
`ifndef LZW_BYTE_COMPRESSOR_ASSERT_SVH
`define LZW_BYTE_COMPRESSOR_ASSERT_SVH

`ifndef SYNTHESIS
// property that must hold at every clock edge out of reset
`define LZWC_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// condition that must never be seen at a clock edge out of reset
`define LZWC_ASSERT_NEVER(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) !(expr)) else $error(msg);
`else
`define LZWC_ASSERT(label, clk, rst, prop, msg)
`define LZWC_ASSERT_NEVER(label, clk, rst, expr, msg)
`endif

`endif

FILE: rtl/core/lzwc_pkg.sv
package lzwc_pkg;

   // code and dictionary sizing
   localparam int DICT_ENTRIES = 4096;
   localparam int CODE_W       = 12;
   localparam int BYTE_W       = 8;
   localparam int CODE_SPACE   = 1 << CODE_W;
   localparam int CODE_LIMIT   = (DICT_ENTRIES < CODE_SPACE) ? DICT_ENTRIES : CODE_SPACE;
   localparam int FREE_W       = CODE_W + 1;
   localparam int FIRST_FREE   = 1 << BYTE_W;
   localparam int KEY_W        = CODE_W + BYTE_W;

   // hash table at least twice the number of codes, so a probe always ends
   localparam int HASH_BITS    = $clog2(CODE_LIMIT) + 1;
   localparam int HASH_SLOTS   = 1 << HASH_BITS;
   localparam int EPOCH_W      = 8;

   typedef logic [CODE_W-1:0]    code_type;
   typedef logic [BYTE_W-1:0]    byte_type;
   typedef logic [FREE_W-1:0]    free_type;
   typedef logic [HASH_BITS-1:0] hash_type;
   typedef logic [EPOCH_W-1:0]   epoch_type;

   // one hash slot: stream epoch, key pair and the code it stands for
   typedef struct packed {
      epoch_type epoch;
      code_type  prefix;
      byte_type  data;
      code_type  code;
   } slot_type;

   // port of the dictionary memory
   typedef struct packed {
      logic     wr_en;
      hash_type wr_addr;
      slot_type wr_data;
      hash_type rd_addr;
   } dict_req_type;

   // code handed to the output queue
   typedef struct packed {
      logic     push;
      code_type code;
      logic     last;
   } emit_type;

   // fold the (prefix, byte) key down to a slot index
   function automatic hash_type hash_index(code_type prefix, byte_type data);
      logic [KEY_W-1:0] key;
      key = {data, prefix};
      return key[HASH_BITS-1:0] ^ hash_type'(key >> HASH_BITS);
   endfunction

endpackage

FILE: rtl/core/lzwc_dict_ram.sv
module lzwc_dict_ram (
   input  logic                  clock,
   input  lzwc_pkg::dict_req_type dict_req,
   output lzwc_pkg::slot_type     rd_data
);

   lzwc_pkg::slot_type slot_mem_ff [lzwc_pkg::HASH_SLOTS];
   lzwc_pkg::slot_type rd_data_ff;

   // single write port, registered read port
   always_ff @(posedge clock) begin
      if (dict_req.wr_en) begin
         slot_mem_ff[dict_req.wr_addr] <= dict_req.wr_data;
      end
      rd_data_ff <= slot_mem_ff[dict_req.rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: rtl/core/lzwc_out_q.sv
`include "lzw_byte_compressor_assert.svh"

module lzwc_out_q (
   input  logic                clock,
   input  logic                reset,
   input  lzwc_pkg::emit_type  emit,
   output logic                emit_ready,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lzwc_pkg::code_type  rsp_code,
   output logic                rsp_last_code
);

   typedef struct packed {
      lzwc_pkg::code_type code;
      logic               last;
   } entry_type;

   entry_type  entry_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       push, pop;

   // two-entry queue between the sequencer and the result channel
   assign emit_ready = (count_ff != 2'd2);
   assign push       = emit.push && emit_ready;
   assign pop        = (count_ff != 2'd0) && !rsp_stall;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = !wr_ptr_ff;
      end
      if (pop) begin
         rd_ptr_in = !rd_ptr_ff;
      end
      if (push && !pop) begin
         count_in = count_ff + 2'd1;
      end else if (pop && !push) begin
         count_in = count_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // queue storage
   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= '{code: emit.code, last: emit.last};
      end
   end

   assign rsp_valid     = (count_ff != 2'd0);
   assign rsp_code      = entry_ff[rd_ptr_ff].code;
   assign rsp_last_code = entry_ff[rd_ptr_ff].last;

   `LZWC_ASSERT_NEVER(a_q_overfill, clock, reset, count_ff > 2'd2, "output queue over two items")
   `LZWC_ASSERT(a_q_count, clock, reset, (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1), "queue count lost a push")

endmodule

FILE: rtl/core/lzwc_ctrl.sv
`include "lzw_byte_compressor_assert.svh"

module lzwc_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  lzwc_pkg::byte_type     req_data_byte,
   input  logic                   req_end_of_stream,
   output lzwc_pkg::dict_req_type dict_req,
   input  lzwc_pkg::slot_type     dict_rd_data,
   output lzwc_pkg::emit_type     emit,
   input  logic                   emit_ready
);

   typedef enum logic [5:0] {
      ST_CLEAR     = 6'b000001,
      ST_IDLE      = 6'b000010,
      ST_READ      = 6'b000100,
      ST_COMPARE   = 6'b001000,
      ST_PUSH_MISS = 6'b010000,
      ST_PUSH_LAST = 6'b100000
   } state_type;

   state_type           state_ff, state_in;
   lzwc_pkg::hash_type  clear_idx_ff, clear_idx_in;
   lzwc_pkg::epoch_type epoch_ff, epoch_in;
   lzwc_pkg::code_type  prefix_ff, prefix_in;
   logic                prefix_valid_ff, prefix_valid_in;
   lzwc_pkg::free_type  next_free_ff, next_free_in;
   lzwc_pkg::hash_type  probe_ff, probe_in;
   lzwc_pkg::byte_type  byte_ff, byte_in;
   logic                eos_ff, eos_in;
   lzwc_pkg::code_type  emit_code_ff, emit_code_in;
   logic                slot_live, slot_hit;

   // a slot counts only if written in the current stream epoch
   assign slot_live = (dict_rd_data.epoch == epoch_ff);
   assign slot_hit  = slot_live && (dict_rd_data.prefix == prefix_ff)
                      && (dict_rd_data.data == byte_ff);

   assign req_stall = (state_ff != ST_IDLE);

   // sequencer: table clear, lookup, probe, insert and emit
   always_comb begin
      state_in        = state_ff;
      clear_idx_in    = clear_idx_ff;
      epoch_in        = epoch_ff;
      prefix_in       = prefix_ff;
      prefix_valid_in = prefix_valid_ff;
      next_free_in    = next_free_ff;
      probe_in        = probe_ff;
      byte_in         = byte_ff;
      eos_in          = eos_ff;
      emit_code_in    = emit_code_ff;
      dict_req        = '0;
      dict_req.rd_addr = probe_ff;
      emit            = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            dict_req.wr_en   = 1'b1;
            dict_req.wr_addr = clear_idx_ff;
            clear_idx_in     = clear_idx_ff + 1'b1;
            if (clear_idx_ff == '1) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               byte_in = req_data_byte;
               eos_in  = req_end_of_stream;
               if (!prefix_valid_ff) begin
                  prefix_in       = lzwc_pkg::code_type'(req_data_byte);
                  prefix_valid_in = 1'b1;
                  state_in        = req_end_of_stream ? ST_PUSH_LAST : ST_IDLE;
               end else begin
                  probe_in = lzwc_pkg::hash_index(prefix_ff, req_data_byte);
                  state_in = ST_READ;
               end
            end
         end
         ST_READ: begin
            state_in = ST_COMPARE;
         end
         ST_COMPARE: begin
            if (slot_hit) begin
               prefix_in = dict_rd_data.code;
               state_in  = eos_ff ? ST_PUSH_LAST : ST_IDLE;
            end else if (slot_live) begin
               probe_in = probe_ff + 1'b1;
               state_in = ST_READ;
            end else begin
               // miss: emit the prefix, add the pair in the empty slot while free codes remain
               emit_code_in = prefix_ff;
               if (next_free_ff < lzwc_pkg::free_type'(lzwc_pkg::CODE_LIMIT)) begin
                  dict_req.wr_en   = 1'b1;
                  dict_req.wr_addr = probe_ff;
                  dict_req.wr_data = '{epoch:  epoch_ff,
                                       prefix: prefix_ff,
                                       data:   byte_ff,
                                       code:   next_free_ff[lzwc_pkg::CODE_W-1:0]};
                  next_free_in     = next_free_ff + 1'b1;
               end
               prefix_in = lzwc_pkg::code_type'(byte_ff);
               state_in  = ST_PUSH_MISS;
            end
         end
         ST_PUSH_MISS: begin
            emit.push = 1'b1;
            emit.code = emit_code_ff;
            emit.last = 1'b0;
            if (emit_ready) begin
               state_in = eos_ff ? ST_PUSH_LAST : ST_IDLE;
            end
         end
         ST_PUSH_LAST: begin
            emit.push = 1'b1;
            emit.code = prefix_ff;
            emit.last = 1'b1;
            if (emit_ready) begin
               prefix_in       = '0;
               prefix_valid_in = 1'b0;
               next_free_in    = lzwc_pkg::free_type'(lzwc_pkg::FIRST_FREE);
               state_in        = ST_IDLE;
               // new epoch retires all entries; wrap needs a full clear
               if (next_free_ff != lzwc_pkg::free_type'(lzwc_pkg::FIRST_FREE)) begin
                  if (epoch_ff == '1) begin
                     epoch_in     = lzwc_pkg::epoch_type'(1);
                     clear_idx_in = '0;
                     state_in     = ST_CLEAR;
                  end else begin
                     epoch_in = epoch_ff + 1'b1;
                  end
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_CLEAR;
         clear_idx_ff    <= '0;
         epoch_ff        <= lzwc_pkg::epoch_type'(1);
         prefix_ff       <= '0;
         prefix_valid_ff <= 1'b0;
         next_free_ff    <= lzwc_pkg::free_type'(lzwc_pkg::FIRST_FREE);
      end else begin
         state_ff        <= state_in;
         clear_idx_ff    <= clear_idx_in;
         epoch_ff        <= epoch_in;
         prefix_ff       <= prefix_in;
         prefix_valid_ff <= prefix_valid_in;
         next_free_ff    <= next_free_in;
      end
   end

   // per-item payload
   always_ff @(posedge clock) begin
      probe_ff     <= probe_in;
      byte_ff      <= byte_in;
      eos_ff       <= eos_in;
      emit_code_ff <= emit_code_in;
   end

   `LZWC_ASSERT_NEVER(a_free_range, clock, reset, next_free_ff > lzwc_pkg::free_type'(lzwc_pkg::CODE_LIMIT), "next free code past the limit")
   `LZWC_ASSERT_NEVER(a_epoch_zero, clock, reset, (state_ff != ST_CLEAR) && (epoch_ff == '0), "cleared epoch in use")
   `LZWC_ASSERT(a_last_restarts, clock, reset, (emit.push && emit.last && emit_ready) |=> (!prefix_valid_ff && next_free_ff == lzwc_pkg::free_type'(lzwc_pkg::FIRST_FREE)), "stream end did not restart dictionary")

endmodule

FILE: rtl/core/lzw_byte_compressor.sv
// LZW byte compressor with 12-bit codes.
// Input channel req_*: one byte per item plus an end-of-stream flag; the block
// takes an item when req_valid is high and req_stall is low.
// Result channel rsp_*: emitted codes with a last flag on the final code of a
// stream; a code is taken when rsp_valid is high and rsp_stall is low.
// Dictionary lookup is a hash table probed through one read port: each probe
// passes through a read state and a compare state, and an item that emits a
// code also passes through a push state for each code pushed.
// The probe chain on the single memory port sets the rate; items are taken
// one at a time.
// Results go through a two-entry queue, so the next item is taken while
// codes wait; when the receiver stalls and the queue is full the sequencer
// holds and req_stall stays high.
// After reset the hash table is cleared, one slot a cycle, across all 8192 slots
// with req_stall high. The same clear pass runs again after every 255
// streams that added dictionary entries.
module lzw_byte_compressor (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  lzwc_pkg::byte_type  req_data_byte,
   input  logic                req_end_of_stream,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output lzwc_pkg::code_type  rsp_code,
   output logic                rsp_last_code
);

   lzwc_pkg::dict_req_type dict_req;
   lzwc_pkg::slot_type     dict_rd_data;
   lzwc_pkg::emit_type     emit;
   logic                   emit_ready;

   // sequencer
   lzwc_ctrl u_ctrl (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .dict_req          (dict_req),
      .dict_rd_data      (dict_rd_data),
      .emit              (emit),
      .emit_ready        (emit_ready)
   );

   // dictionary hash table
   lzwc_dict_ram u_dict_ram (
      .clock    (clock),
      .dict_req (dict_req),
      .rd_data  (dict_rd_data)
   );

   // result queue
   lzwc_out_q u_out_q (
      .clock         (clock),
      .reset         (reset),
      .emit          (emit),
      .emit_ready    (emit_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_code      (rsp_code),
      .rsp_last_code (rsp_last_code)
   );

endmodule

FILE: tb/lzw_byte_compressor_checker.sv
module lzw_byte_compressor_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  lzwc_pkg::byte_type req_data_byte,
   input  logic               req_end_of_stream,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  lzwc_pkg::code_type rsp_code,
   input  logic               rsp_last_code,
   output int                 mismatch_count,
   output int                 pending_codes,
   output int                 codes_checked
);

   typedef logic [lzwc_pkg::KEY_W-1:0] pair_key_type;

   // one code the compressor owes the receiver
   typedef struct packed {
      lzwc_pkg::code_type code;
      logic               last;
   } owed_code_type;

   // shadow dictionary: (prefix, byte) pair to its assigned code
   lzwc_pkg::code_type pair_codes [pair_key_type];
   int                 next_code;
   lzwc_pkg::code_type cur_prefix;
   logic               holding;
   owed_code_type      owed_codes [$];
   owed_code_type      want;
   int                 mismatches = 0;
   int                 checked = 0;

   // forget the dictionary and the prefix at the end of a stream
   task automatic restart_stream();
      pair_codes.delete();
      next_code  = lzwc_pkg::FIRST_FREE;
      cur_prefix = '0;
      holding    = 1'b0;
   endtask

   task automatic report_mismatch(input string what);
      $display("mismatch at code %0d: %s", checked, what);
      mismatches++;
   endtask

   // lzw step for one accepted byte, queues the codes it emits
   task automatic compress_byte(input lzwc_pkg::byte_type data, input logic eos);
      pair_key_type key;
      key = {cur_prefix, data};
      if (!holding) begin
         cur_prefix = lzwc_pkg::code_type'(data);
         holding    = 1'b1;
      end else if (pair_codes.exists(key)) begin
         cur_prefix = pair_codes[key];
      end else begin
         owed_codes.push_back('{code: cur_prefix, last: 1'b0});
         // dictionary stops growing once full
         if (next_code < lzwc_pkg::CODE_LIMIT) begin
            pair_codes[key] = lzwc_pkg::code_type'(next_code);
            next_code++;
         end
         cur_prefix = lzwc_pkg::code_type'(data);
      end
      if (eos) begin
         owed_codes.push_back('{code: cur_prefix, last: 1'b1});
         restart_stream();
      end
   endtask

   // watch both channels at each edge
   always @(posedge clock) begin
      if (reset) begin
         restart_stream();
         owed_codes.delete();
      end else begin
         if (req_valid && !req_stall) begin
            compress_byte(req_data_byte, req_end_of_stream);
         end
         if (rsp_valid && !rsp_stall) begin
            if (owed_codes.size() == 0) begin
               report_mismatch($sformatf("code %0d last %0b with nothing expected",
                  rsp_code, rsp_last_code));
            end else begin
               want = owed_codes.pop_front();
               if (rsp_code !== want.code) begin
                  report_mismatch($sformatf("code %0d, expected %0d", rsp_code, want.code));
               end
               if (rsp_last_code !== want.last) begin
                  report_mismatch($sformatf("last flag %0b, expected %0b",
                     rsp_last_code, want.last));
               end
            end
            checked++;
         end
      end
      mismatch_count <= mismatches;
      pending_codes  <= owed_codes.size();
      codes_checked  <= checked;
   end

endmodule

FILE: tb/tb_lzw_byte_compressor.sv
module tb_lzw_byte_compressor;

   localparam int RUN_LIMIT    = 1000000;
   localparam int IDLE_PCT     = 13;
   localparam int RANDOM_BYTES = 1830;
   localparam int MULTI_BYTE   = 270;
   localparam int DRAIN_CYCLES = 40;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               req_valid = 1'b0;
   logic               req_stall;
   lzwc_pkg::byte_type req_data_byte = '0;
   logic               req_end_of_stream = 1'b0;
   logic               rsp_valid;
   logic               rsp_stall = 1'b0;
   lzwc_pkg::code_type rsp_code;
   logic               rsp_last_code;

   int   mismatch_count;
   int   pending_codes;
   int   codes_checked;
   int   cycle_count = 0;
   int   bytes_sent = 0;
   int   streams_sent = 0;
   logic steady;

   lzw_byte_compressor dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_code          (rsp_code),
      .rsp_last_code     (rsp_last_code)
   );

   lzw_byte_compressor_checker u_checker (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_data_byte     (req_data_byte),
      .req_end_of_stream (req_end_of_stream),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_code          (rsp_code),
      .rsp_last_code     (rsp_last_code),
      .mismatch_count    (mismatch_count),
      .pending_codes     (pending_codes),
      .codes_checked     (codes_checked)
   );

   always #5 clock = ~clock;

   // stretch of full-rate traffic on both sides
   assign steady = (bytes_sent >= 300) && (bytes_sent < 700);

   // receiver backpressure
   always @(posedge clock) begin
      rsp_stall <= !steady && ($urandom_range(0, 99) < IDLE_PCT);
   end

   // run watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   // offer one byte, hold it until the block takes it
   task automatic send_byte(input lzwc_pkg::byte_type data, input logic eos);
      while (!steady && ($urandom_range(0, 99) < IDLE_PCT)) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid         <= 1'b1;
      req_data_byte     <= data;
      req_end_of_stream <= eos;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      bytes_sent++;
      if (eos) streams_sent++;
   endtask

   initial begin
      string              word;
      lzwc_pkg::byte_type base;
      lzwc_pkg::byte_type data;
      int                 len;
      int                 pick;
      int                 mode;
      int                 random_bytes;
      int                 multi_streams;

      random_bytes  = 0;
      multi_streams = 0;

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      // one-byte streams at both byte extremes
      send_byte(8'h00, 1'b1);
      send_byte(8'hFF, 1'b1);
      // run of one byte ending on a miss, then one ending on a hit
      repeat (3) send_byte(8'hFF, 1'b0);
      send_byte(8'hFF, 1'b1);
      repeat (2) send_byte(8'h00, 1'b0);
      send_byte(8'h00, 1'b1);
      // prefix grows through entries added in the same stream
      word = "ABABABA";
      for (int k = 0; k < word.len(); k++) begin
         send_byte(lzwc_pkg::byte_type'(word[k]), k == word.len() - 1);
      end
      // alternating bit patterns
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b0);
      send_byte(8'h55, 1'b0);
      send_byte(8'hAA, 1'b1);

      // random streams, mostly short and over small byte sets to get repeats;
      // enough multi-byte streams to roll the slot epoch over
      while (random_bytes < RANDOM_BYTES || multi_streams < MULTI_BYTE) begin
         pick = $urandom_range(0, 99);
         if (pick < 10) len = 1;
         else if (pick < 85) len = $urandom_range(2, 5);
         else if (pick < 98) len = $urandom_range(6, 20);
         else len = $urandom_range(21, 60);
         mode = $urandom_range(0, 2);
         base = lzwc_pkg::byte_type'($urandom);
         for (int k = 0; k < len; k++) begin
            case (mode)
               0: begin
                  data = $urandom_range(0, 1) ? base : ~base;
               end
               1: begin
                  data = base + lzwc_pkg::byte_type'($urandom_range(0, 3));
               end
               default: begin
                  data = lzwc_pkg::byte_type'($urandom);
               end
            endcase
            send_byte(data, k == len - 1);
         end
         random_bytes += len;
         if (len > 1) multi_streams++;
      end
      req_valid <= 1'b0;

      // drain the codes still owed
      @(posedge clock);
      while (pending_codes != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("compressed %0d bytes in %0d streams, short and long, with repeats",
         bytes_sent, streams_sent);
      $display("%0d codes compared, %0d mismatches", codes_checked, mismatch_count);
      if (mismatch_count == 0) begin
         $display("All tests passed");
      end else begin
         $display("Some tests failed");
      end
      $finish;
   end

endmodule
